@@ hdl/ldsc_pkg.sv @@
// Shared constants and types for the DE-mode LCD pixel capture block.
`default_nettype none
package ldsc_pkg;

  // Internal counter widths.
  localparam int COORD_BITS = 11;
  localparam int GAP_BITS   = 16;

  // Fixed widths of the register and output fields.
  localparam int DIM_W = 11;
  localparam int THR_W = 16;

  // Comparison widths: wide enough for counter and register alike.
  localparam int CMP_CW = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
  localparam int CMP_GW = (GAP_BITS > THR_W) ? GAP_BITS : THR_W;

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
  localparam logic [GAP_BITS-1:0]   GAP_MAX   = {GAP_BITS{1'b1}};

  // Register reset values.
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(480);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(272);
  localparam logic [THR_W-1:0] LINE_GAP_RESET     = THR_W'(40);
  localparam logic [THR_W-1:0] FRAME_GAP_RESET    = THR_W'(5 * 520);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = THR_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_LINE_GAP_MIN  = 2'd2,
    REG_FRAME_GAP_MIN = 2'd3
  } ldsc_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [THR_W-1:0] line_gap_min;
    logic [THR_W-1:0] frame_gap_min;
  } ldsc_cfg_t;

  typedef struct packed {
    logic             frame_start;
    logic             pixel_valid;
    logic [DIM_W-1:0] pixel_x;
    logic [DIM_W-1:0] pixel_y;
  } ldsc_result_t;

endpackage
`default_nettype wire

@@ hdl/ldsc_sync_tracker.sv @@
// Gap, column and row counters that recover line and frame timing from DE.
`default_nettype none
module ldsc_sync_tracker
  import ldsc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ldsc_cfg_t    cfg,
  input  wire logic         step,
  input  wire logic         de,
  output ldsc_result_t      result
);

  logic [GAP_BITS-1:0]   low_gap_r,  low_gap_nxt;
  logic [COORD_BITS-1:0] column_r,   column_nxt;
  logic [COORD_BITS-1:0] row_r,      row_nxt;

  logic                  frame_hit;
  logic                  line_hit;
  logic                  in_area;
  logic [COORD_BITS-1:0] col_base;
  logic [COORD_BITS-1:0] row_base;

  always_comb begin
    frame_hit = CMP_GW'(low_gap_r) >= CMP_GW'(cfg.frame_gap_min);
    line_hit  = CMP_GW'(low_gap_r) >= CMP_GW'(cfg.line_gap_min);

    col_base = column_r;
    row_base = row_r;
    if (frame_hit) begin
      col_base = '0;
      row_base = '0;
    end else if (line_hit) begin
      col_base = '0;
      if (row_r != COORD_MAX) begin
        row_base = row_r + COORD_BITS'(1);
      end
    end

    in_area = (CMP_CW'(col_base) < CMP_CW'(cfg.frame_width)) &&
              (CMP_CW'(row_base) < CMP_CW'(cfg.frame_height));

    result.frame_start = frame_hit;
    result.pixel_valid = in_area;
    result.pixel_x     = DIM_W'(col_base);
    result.pixel_y     = DIM_W'(row_base);

    low_gap_nxt = low_gap_r;
    column_nxt  = column_r;
    row_nxt     = row_r;
    if (step) begin
      if (!de) begin
        // count one more low edge, saturating
        if (low_gap_r != GAP_MAX) begin
          low_gap_nxt = low_gap_r + GAP_BITS'(1);
        end
      end else begin
        low_gap_nxt = '0;
        row_nxt     = row_base;
        column_nxt  = col_base;
        if (in_area && (col_base != COORD_MAX)) begin
          column_nxt = col_base + COORD_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_gap_r <= '0;
      column_r  <= '0;
      row_r     <= '0;
    end else begin
      low_gap_r <= low_gap_nxt;
      column_r  <= column_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lcd_de_sync_pixel_capture.sv @@
// Top level of the DE-mode LCD pixel capture: config registers and output stage.
// A DE-high request shows its result on the output in the cycle after it is accepted.
// Throughput: one request per cycle while the output drains; gap/column/row update per request.
// DE-low requests update the gap counter only and give no result.
// Reset (synchronous, rst_n low): counters to zero, output empty, registers to
// width 480, height 272, line gap 40, frame gap 2600.
`default_nettype none
module lcd_de_sync_pixel_capture
  import ldsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pixel clock edge requests
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // [15:0] pixel_data
  input  wire logic [0:0]            in_tuser,   // [0] de
  // captured pixels
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [39:0]                out_tdata,  // [10:0] pixel_x, [21:11] pixel_y,
                                                 // [37:22] pixel_value, [39:38] zero
  output logic [1:0]                 out_tuser,  // [0] frame_start, [1] pixel_valid
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  ldsc_cfg_t    cfg_r;
  ldsc_result_t result;
  logic         in_accept;

  logic         out_valid_r, out_valid_nxt;
  ldsc_result_t out_res_r;
  logic [15:0]  out_pixel_r;

  // Take a new request whenever the output stage is empty or drains this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= FRAME_WIDTH_RESET;
      cfg_r.frame_height  <= FRAME_HEIGHT_RESET;
      cfg_r.line_gap_min  <= LINE_GAP_RESET;
      cfg_r.frame_gap_min <= FRAME_GAP_RESET;
    end else if (cfg_we) begin
      unique case (ldsc_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:   cfg_r.frame_width   <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:  cfg_r.frame_height  <= cfg_wdata[DIM_W-1:0];
        REG_LINE_GAP_MIN:  cfg_r.line_gap_min  <= cfg_wdata[THR_W-1:0];
        REG_FRAME_GAP_MIN: cfg_r.frame_gap_min <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Timing recovery: counters advance only on an accepted request.
  ldsc_sync_tracker u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .step   (in_accept),
    .de     (in_tuser[0]),
    .result (result)
  );

  // Output stage: load a result for every accepted DE-high request, hold it
  // while the sink stalls, drop the valid once it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept && in_tuser[0]) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_accept && in_tuser[0]) begin
      out_res_r   <= result;
      out_pixel_r <= in_tdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pixel_r, out_res_r.pixel_y, out_res_r.pixel_x};
  assign out_tuser  = {out_res_r.pixel_valid, out_res_r.frame_start};

endmodule
`default_nettype wire

@@ hdl/ldsc_checker.sv @@
// Port-level checks on the pixel capture, bound to the top level.
`default_nettype none
module ldsc_checker
  import ldsc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [15:0]           in_tdata,
  input wire logic [0:0]            in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [39:0]           out_tdata,
  input wire logic [1:0]            out_tuser
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A DE-high request always yields a result next cycle.
  a_high_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> out_tvalid && (out_tdata[37:22] == $past(in_tdata)))
    else $error("DE-high request gave no matching result");

  // A DE-low request with nothing pending leaves the output empty.
  a_low_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] && !(out_tvalid && !out_tready) |=> !out_tvalid)
    else $error("DE-low request produced a result");

  // A frame start lands at the origin.
  a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[21:0] == 22'd0)
    else $error("frame start away from origin");

  // Ready must stay up while the output stage is empty.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind lcd_de_sync_pixel_capture ldsc_checker u_ldsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

@@ test/tb_lcd_de_sync_pixel_capture.sv @@
// Self-checking testbench for the DE-mode LCD pixel capture block.
`timescale 1ns / 1ps

module tb_lcd_de_sync_pixel_capture;
  import ldsc_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  // Settling wait after the last capture, before register writes.
  localparam int SETTLE_CYCLES = 3;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BUDGET  = 180;

  typedef struct packed {
    logic             frame_start;
    logic             pixel_valid;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [15:0]      value;
  } capture_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        de;
    logic [15:0] data;
    ldsc_reg_t   reg_idx;
    logic [15:0] reg_val;
    bit          has_exp;
    capture_t    exp;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [15:0] pixel_data
  logic [0:0]            in_tuser;   // [0] de
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [39:0]           out_tdata;  // [10:0] pixel_x, [21:11] pixel_y,
                                     // [37:22] pixel_value, [39:38] zero
  logic [1:0]            out_tuser;  // [0] frame_start, [1] pixel_valid
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lcd_de_sync_pixel_capture u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block: registers and the gap/column/row counters.
  logic [DIM_W-1:0]      shadow_width;
  logic [DIM_W-1:0]      shadow_height;
  logic [THR_W-1:0]      shadow_line_gap;
  logic [THR_W-1:0]      shadow_frame_gap;
  logic [GAP_BITS-1:0]   gap_cnt;
  logic [COORD_BITS-1:0] col_cnt;
  logic [COORD_BITS-1:0] row_cnt;

  capture_t capture_q[$];     // captures still owed by the block, oldest first
  dir_row_t dir_rows[$];

  bit idle_on = 1'b1;
  int out_stall_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int captures_checked = 0;
  int frame_starts_seen = 0;
  int in_area_seen = 0;
  int reg_writes = 0;

  // Advance the shadow by one pixel clock edge; return 1 when a capture results.
  function automatic bit predict_capture(logic de, logic [15:0] data, output capture_t res);
    res = '0;
    if (!de) begin
      // Count one more low edge, saturating.
      if (gap_cnt != GAP_MAX) gap_cnt++;
      return 1'b0;
    end
    // Frame check wins over the line check when the thresholds cross.
    if (gap_cnt >= shadow_frame_gap) begin
      col_cnt = '0;
      row_cnt = '0;
      res.frame_start = 1'b1;
    end else if (gap_cnt >= shadow_line_gap) begin
      col_cnt = '0;
      if (row_cnt != COORD_MAX) row_cnt++;
    end
    res.x     = col_cnt;
    res.y     = row_cnt;
    res.value = data;
    // Out-of-area pixels still give a capture, but hold the column.
    if (col_cnt < shadow_width && row_cnt < shadow_height) begin
      res.pixel_valid = 1'b1;
      if (col_cnt != COORD_MAX) col_cnt++;
    end
    gap_cnt = '0;
    return 1'b1;
  endfunction

  // Present one request, hold it until accepted, then book its capture.
  task automatic send_item(logic de, logic [15:0] data, bit has_exp = 1'b0,
                           capture_t exp = '0);
    capture_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= de;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    if (predict_capture(de, data, res)) capture_q.push_back(has_exp ? exp : res);
  endtask

  // Drop the request line and hold off until every owed capture has come.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (capture_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ldsc_reg_t idx, logic [15:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   shadow_width     = val[DIM_W-1:0];
      REG_FRAME_HEIGHT:  shadow_height    = val[DIM_W-1:0];
      REG_LINE_GAP_MIN:  shadow_line_gap  = val[THR_W-1:0];
      REG_FRAME_GAP_MIN: shadow_frame_gap = val[THR_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_timing(int width, int height, int line_gap, int frame_gap);
    write_reg(REG_FRAME_WIDTH, width[15:0]);
    write_reg(REG_FRAME_HEIGHT, height[15:0]);
    write_reg(REG_LINE_GAP_MIN, line_gap[15:0]);
    write_reg(REG_FRAME_GAP_MIN, frame_gap[15:0]);
  endtask

  task automatic send_low_run(int n);
    repeat (n) send_item(1'b0, 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_pixels(int n);
    repeat (n) send_item(1'b1, 16'($urandom_range(0, 65535)));
  endtask

  // One well-formed frame: frame gap, then lines split by line gaps. Line
  // length and line count hover around the configured size, capped so that
  // the largest sizes stay cheap.
  task automatic send_frame();
    int eff_w;
    int eff_h;
    int lines;
    eff_w = (shadow_width > 16) ? 16 : ((shadow_width == 0) ? 1 : int'(shadow_width));
    eff_h = (shadow_height > 6) ? 6 : ((shadow_height == 0) ? 1 : int'(shadow_height));
    send_low_run(int'(shadow_frame_gap) + $urandom_range(0, 2));
    lines = $urandom_range(eff_h, eff_h + 1);
    for (int l = 0; l < lines; l++) begin
      if (l > 0) send_low_run(int'(shadow_line_gap) + $urandom_range(0, 1));
      send_pixels($urandom_range((eff_w > 1) ? eff_w - 1 : 1, eff_w + 1));
    end
  endtask

  function automatic void add_item(logic de, logic [15:0] data);
    dir_row_t row;
    row = '{kind: ROW_ITEM, de: de, data: data, reg_idx: REG_FRAME_WIDTH,
            reg_val: '0, has_exp: 1'b0, exp: '0};
    dir_rows.push_back(row);
  endfunction

  // A DE-high request whose capture is plain to see.
  function automatic void add_check(logic [15:0] data, logic fs, logic pv,
                                    int x, int y);
    dir_row_t row;
    row = '{kind: ROW_ITEM, de: 1'b1, data: data, reg_idx: REG_FRAME_WIDTH,
            reg_val: '0, has_exp: 1'b1, exp: '0};
    row.exp.frame_start = fs;
    row.exp.pixel_valid = pv;
    row.exp.x           = x[DIM_W-1:0];
    row.exp.y           = y[DIM_W-1:0];
    row.exp.value       = data;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(ldsc_reg_t idx, logic [15:0] val);
    dir_row_t row;
    row = '{kind: ROW_CFG, de: 1'b0, data: '0, reg_idx: idx, reg_val: val,
            has_exp: 1'b0, exp: '0};
    dir_rows.push_back(row);
  endfunction

  // Output side: stall in random bursts while idling is on.
  always @(posedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (out_stall_left > 0) begin
      out_tready     <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready     <= 1'b0;
      out_stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare every accepted capture against the oldest one owed.
  always @(posedge clk) begin : capture_monitor
    capture_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (capture_q.size() == 0) begin
        $display("%0t ns: unexpected capture, expected none, actual tdata %h tuser %h",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = capture_q.pop_front();
        check_field("frame_start", 16'(want.frame_start), 16'(out_tuser[0]));
        check_field("pixel_valid", 16'(want.pixel_valid), 16'(out_tuser[1]));
        check_field("pixel_x", 16'(want.x), 16'(out_tdata[10:0]));
        check_field("pixel_y", 16'(want.y), 16'(out_tdata[21:11]));
        check_field("pixel_value", want.value, out_tdata[37:22]);
        check_field("tdata pad", 16'd0, 16'(out_tdata[39:38]));
        captures_checked++;
        if (want.frame_start) frame_starts_seen++;
        if (want.pixel_valid) in_area_seen++;
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("run stopped after %0d cycles with %0d captures still owed",
             cycle_count, capture_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_FRAME_WIDTH;
    cfg_wdata = '0;
    rst_n     = 1'b0;

    shadow_width     = FRAME_WIDTH_RESET;
    shadow_height    = FRAME_HEIGHT_RESET;
    shadow_line_gap  = LINE_GAP_RESET;
    shadow_frame_gap = FRAME_GAP_RESET;
    gap_cnt = '0;
    col_cnt = '0;
    row_cnt = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reset timing first: pixels land in order on row 0.
    add_check(16'h0000, 1'b0, 1'b1, 0, 0);
    add_check(16'hFFFF, 1'b0, 1'b1, 1, 0);
    add_item(1'b0, 16'hFFFF);
    add_check(16'h5A5A, 1'b0, 1'b1, 2, 0);
    // Shrink the area to 2x2 and the gaps to 2 and 4.
    add_cfg(REG_FRAME_WIDTH, 16'd2);
    add_cfg(REG_FRAME_HEIGHT, 16'd2);
    add_cfg(REG_LINE_GAP_MIN, 16'd2);
    add_cfg(REG_FRAME_GAP_MIN, 16'd4);
    // Column already past the width: out of area, column holds.
    add_check(16'h1234, 1'b0, 1'b0, 3, 0);
    add_item(1'b0, 16'h0000);
    add_item(1'b0, 16'hFFFF);
    add_check(16'h0001, 1'b0, 1'b1, 0, 1);
    add_check(16'h0002, 1'b0, 1'b1, 1, 1);
    add_check(16'h0003, 1'b0, 1'b0, 2, 1);
    add_item(1'b0, 16'h0000);
    add_item(1'b0, 16'h0000);
    // Row now at the height: out of area.
    add_check(16'h0004, 1'b0, 1'b0, 0, 2);
    repeat (4) add_item(1'b0, 16'hAAAA);
    add_check(16'h0005, 1'b1, 1'b1, 0, 0);
    // Zero frame threshold: even a zero gap starts a frame.
    add_cfg(REG_FRAME_GAP_MIN, 16'd0);
    add_check(16'h0006, 1'b1, 1'b1, 0, 0);
    // Crossed thresholds: the frame check takes a gap meant as a line gap.
    add_cfg(REG_FRAME_GAP_MIN, 16'd1);
    add_cfg(REG_LINE_GAP_MIN, 16'd3);
    repeat (3) add_item(1'b0, 16'h5555);
    add_item(1'b1, 16'h0007);
    // Width write with bit 11 set masks to zero: nothing is in area.
    add_cfg(REG_FRAME_WIDTH, 16'h0800);
    add_item(1'b1, 16'h0008);
    // Height write with high bits masks to the largest height.
    add_cfg(REG_FRAME_HEIGHT, 16'h0FFF);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else
        send_item(dir_rows[i].de, dir_rows[i].data, dir_rows[i].has_exp, dir_rows[i].exp);
    end

    // Long low runs: one edge short of the frame gap gives a new line, the
    // full frame gap gives a frame start.
    set_timing(2047, 2047, 60, 120);
    send_pixels(1);
    send_low_run(119);
    send_pixels(1);
    send_low_run(120);
    send_pixels(2);

    // Row past the height: one-pixel lines run off the bottom of the area.
    set_timing(1, 4, 1, 65535);
    repeat (6) begin
      send_low_run(1);
      send_pixels(1);
    end

    // Long line: the column runs off the width and holds there.
    set_timing(8, 2047, 1, 2);
    send_low_run(2);
    send_pixels(12);

    // Random part: mostly well-formed frames with random content, some noise
    // and broken gaps. Idle off in the fourth and the last phase.
    for (int p = 0; p < RANDOM_PHASES; p++) begin : random_phase
      int phase_start;
      int lg;
      int fg;
      idle_on = (p != 3) && (p != RANDOM_PHASES - 1);
      case (p)
        0: begin
          lg = $urandom_range(1, 3);
          set_timing(2047, 2047, lg, lg + $urandom_range(1, 4));
        end
        1: begin
          fg = $urandom_range(1, 3);
          set_timing($urandom_range(2, 8), $urandom_range(2, 4), fg + $urandom_range(0, 3), fg);
        end
        2: set_timing($urandom_range(2, 8), $urandom_range(2, 5), 0, $urandom_range(2, 5));
        3: set_timing(1, 1, 1, 3);
        default: begin
          lg = $urandom_range(1, 4);
          set_timing($urandom_range(1, 10), $urandom_range(1, 5), lg, lg + $urandom_range(1, 5));
        end
      endcase
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_BUDGET) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 4))
               send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
          1: begin
            send_low_run($urandom_range(0, int'(shadow_frame_gap) + 1));
            send_pixels($urandom_range(1, 3));
          end
          default: send_frame();
        endcase
        // Now and then hold the sender until the output side has caught up.
        if (idle_on && $urandom_range(0, 29) == 0) wait_drained();
      end
    end

    in_tvalid <= 1'b0;
    while (capture_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d register writes over reset, extreme and random timing",
             requests_sent, reg_writes);
    $display("checked %0d captures: %0d frame starts, %0d in area, %0d mismatches",
             captures_checked, frame_starts_seen, in_area_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
